FILE: hw/rtl/imvt_pkg.sv
// ----------------------------------------------------------------------------
// imvt_pkg: shared definitions for the integer matrix-vector transform
// Element widths, matrix size, item codes, lane control and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package imvt_pkg;

   localparam int MAX_DIM    = 4;
   localparam int ELEM_WIDTH = 32;
   localparam int FIELD_W    = 32;
   localparam int FIELDS     = 4;
   localparam int DIM_W      = 3;

   // Item codes carried on the mode field
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   typedef logic [ELEM_WIDTH-1:0]             elem_type;
   typedef logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] vec_type;
   typedef logic [FIELDS-1:0][FIELD_W-1:0]     field_vec_type;

   typedef struct packed {
      logic               advance;
      logic [MAX_DIM-1:0] col_en;
   } lane_ctrl_type;

   // Sign-extend a port field, keep it at element width
   function automatic elem_type take_elem(input logic [FIELD_W-1:0] raw);
      logic [FIELD_W+ELEM_WIDTH-1:0] ext;
      ext = {{ELEM_WIDTH{raw[FIELD_W-1]}}, raw};
      return ext[ELEM_WIDTH-1:0];
   endfunction

   // Sign-extend an element, cut it to the port field width
   function automatic logic [FIELD_W-1:0] give_elem(input elem_type v);
      logic [FIELD_W+ELEM_WIDTH-1:0] ext;
      ext = {{FIELD_W{v[ELEM_WIDTH-1]}}, v};
      return ext[FIELD_W-1:0];
   endfunction

   // Clamp the dimension register to the supported sizes
   function automatic logic [DIM_W-1:0] active_size(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] n;
      n = d;
      if (n < DIM_W'(2)) begin
         n = DIM_W'(2);
      end
      if (n > DIM_W'(MAX_DIM)) begin
         n = DIM_W'(MAX_DIM);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/imvt_lane.sv
// ----------------------------------------------------------------------------
// imvt_lane: one matrix row times the vector
// Registers the masked row-by-vector products, then sums them.
// ----------------------------------------------------------------------------
`default_nettype none

module imvt_lane (
   input  wire logic                    clock,
   input  wire imvt_pkg::lane_ctrl_type ctrl,
   input  wire imvt_pkg::vec_type       row_elems,
   input  wire imvt_pkg::vec_type       vec,
   output      imvt_pkg::elem_type      dot
);

   imvt_pkg::vec_type products_ff;
   imvt_pkg::vec_type products_in;

   // Multiply each active column, drop the inactive ones
   always_comb begin
      for (int j = 0; j < imvt_pkg::MAX_DIM; j++) begin
         products_in[j] = ctrl.col_en[j] ? imvt_pkg::elem_type'(row_elems[j] * vec[j])
                                         : '0;
      end
   end

   // Hold products while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         products_ff <= products_in;
      end
   end

   // Sum the products, wrapping at element width
   always_comb begin
      dot = '0;
      for (int j = 0; j < imvt_pkg::MAX_DIM; j++) begin
         dot = dot + products_ff[j];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/imvt_merge.sv
// ----------------------------------------------------------------------------
// imvt_merge: result assembly and output register
// Collects the lane sums, zeroes rows beyond the active size, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module imvt_merge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire imvt_pkg::vec_type              lane_dots,
   input  wire logic [imvt_pkg::DIM_W-1:0]     size,
   output      logic                           take,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      imvt_pkg::field_vec_type        rsp_data
);

   logic                    valid_ff;
   logic                    valid_in;
   imvt_pkg::field_vec_type data_ff;
   imvt_pkg::field_vec_type data_in;

   // Output register is free when empty or being drained
   assign take = !valid_ff || rsp_ready;

   // Zero rows at or beyond the active size
   always_comb begin
      for (int i = 0; i < imvt_pkg::FIELDS; i++) begin
         data_in[i] = '0;
         if (i < imvt_pkg::MAX_DIM && i < int'(size)) begin
            data_in[i] = imvt_pkg::give_elem(lane_dots[i]);
         end
      end
   end

   assign valid_in = take ? in_valid : valid_ff;

   // Track the held transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/int_matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// int_matrix_vector_transform: 4x4 integer matrix times vector
// Column loads update the stored matrix; transforms return matrix * vector.
// ----------------------------------------------------------------------------
// A transform passes the product register of each row lane, then the output
// register, before it shows on rsp_valid. One multiplier per matrix element.
// Throughput: one transaction per cycle, unless rsp_ready stalls the output.
// Loads take effect for a transform accepted in the next cycle.
// Reset: matrix becomes the identity, dimension becomes 4, pipeline empties.
`default_nettype none

module int_matrix_vector_transform (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_mode,
   input  wire logic [1:0]  req_column_index,
   input  wire logic [31:0] req_elem_x,
   input  wire logic [31:0] req_elem_y,
   input  wire logic [31:0] req_elem_z,
   input  wire logic [31:0] req_elem_w,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_out_x,
   output      logic [31:0] rsp_out_y,
   output      logic [31:0] rsp_out_z,
   output      logic [31:0] rsp_out_w
);

   localparam int MD = imvt_pkg::MAX_DIM;

   logic [imvt_pkg::DIM_W-1:0] dimension_ff;
   logic [imvt_pkg::DIM_W-1:0] size;
   imvt_pkg::vec_type          matrix_ff [MD];
   imvt_pkg::vec_type          matrix_in [MD];
   imvt_pkg::vec_type          vec;
   imvt_pkg::vec_type          row_elems [MD];
   imvt_pkg::vec_type          lane_dots;
   imvt_pkg::field_vec_type    fields;
   imvt_pkg::field_vec_type    rsp_data;
   imvt_pkg::lane_ctrl_type    lane_ctrl;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_advance;
   logic                       take;
   logic                       req_fire;
   logic                       xform_fire;
   logic                       load_fire;

   // Dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= imvt_pkg::DIM_W'(4);
      end else if (csr_wr_en) begin
         dimension_ff <= csr_wr_data;
      end
   end

   assign size = imvt_pkg::active_size(dimension_ff);

   // Unpack the input vector at element width
   assign fields = {req_elem_w, req_elem_z, req_elem_y, req_elem_x};
   always_comb begin
      for (int j = 0; j < MD; j++) begin
         vec[j] = imvt_pkg::take_elem(fields[j]);
      end
   end

   // Handshake and pipeline advance
   assign s1_advance  = !s1_valid_ff || take;
   assign req_ready   = s1_advance;
   assign req_fire    = req_valid && req_ready;
   assign xform_fire  = req_fire && (req_mode == imvt_pkg::MODE_XFORM);
   assign load_fire   = req_fire && (req_mode == imvt_pkg::MODE_LOAD);
   assign s1_valid_in = s1_advance ? xform_fire : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Write one column on a load
   always_comb begin
      for (int c = 0; c < MD; c++) begin
         matrix_in[c] = matrix_ff[c];
         if (load_fire && int'(req_column_index) == c) begin
            matrix_in[c] = vec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MD; c++) begin
            for (int r = 0; r < MD; r++) begin
               matrix_ff[c][r] <= (c == r) ? imvt_pkg::elem_type'(1) : '0;
            end
         end
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   // Lane control: columns inside the active size
   always_comb begin
      lane_ctrl.advance = s1_advance;
      for (int j = 0; j < MD; j++) begin
         lane_ctrl.col_en[j] = (j < int'(size));
      end
   end

   // One lane per matrix row
   for (genvar i = 0; i < MD; i++) begin : g_lane
      always_comb begin
         for (int j = 0; j < MD; j++) begin
            row_elems[i][j] = matrix_ff[j][i];
         end
      end

      imvt_lane u_lane (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .row_elems (row_elems[i]),
         .vec       (vec),
         .dot       (lane_dots[i])
      );
   end

   imvt_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .lane_dots (lane_dots),
      .size      (size),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_x = rsp_data[0];
   assign rsp_out_y = rsp_data[1];
   assign rsp_out_z = rsp_data[2];
   assign rsp_out_w = rsp_data[3];

   // A transform accepted into an empty lane stage is there next cycle
   assert property (@(posedge clock) disable iff (reset)
      xform_fire |=> s1_valid_ff)
      else $error("accepted transform lost from lane stage");

   // A load never creates a lane-stage transaction
   assert property (@(posedge clock) disable iff (reset)
      load_fire && !s1_valid_ff |=> !s1_valid_ff)
      else $error("load produced a result");

   // A stalled output blocks the input only when the lane stage is full
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid && !rsp_ready)
      else $error("input stalled without backpressure");

   // At size two the upper result components are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && size == imvt_pkg::DIM_W'(2) |-> rsp_out_z == '0 && rsp_out_w == '0)
      else $error("inactive result rows not zero");

endmodule

`default_nettype wire

FILE: tb/sv/int_matrix_vector_transform_tb.sv
// ----------------------------------------------------------------------------
// int_matrix_vector_transform_tb: self-checking bench for the matrix transform
// Streams column loads and vector transforms through the request channel,
// predicts each product from a private copy of the matrix and the dimension,
// and compares every response lane against the oldest predicted product.
// ----------------------------------------------------------------------------
`default_nettype none

module int_matrix_vector_transform_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LANES = 4;

   typedef logic [LANES-1:0][31:0] lane_vec_type;

   typedef struct packed {
      logic         mode;
      logic [1:0]   column;
      lane_vec_type elem;
   } xform_req_type;

   // DUT connections, all driven inputs known from time zero
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [2:0]  csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_mode         = imvt_pkg::MODE_LOAD;
   logic [1:0]  req_column_index = '0;
   logic [31:0] req_elem_x       = '0;
   logic [31:0] req_elem_y       = '0;
   logic [31:0] req_elem_z       = '0;
   logic [31:0] req_elem_w       = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic [31:0] rsp_out_w;

   // Predictor state: matrix indexed [column][row], plus the dimension register
   logic [31:0]                model_matrix [LANES][LANES];
   logic [imvt_pkg::DIM_W-1:0] model_dimension = imvt_pkg::DIM_W'(4);

   xform_req_type pending_requests [$];
   lane_vec_type  expected_products [$];
   xform_req_type next_req;
   lane_vec_type  got_product;
   lane_vec_type  want_product;
   int unsigned   queued_count   = 0;
   int unsigned   accepted_count = 0;
   int unsigned   error_count    = 0;
   int            send_idle_pct  = 0;
   int            recv_idle_pct  = 0;
   string         lane_name [LANES] = '{"out_x", "out_y", "out_z", "out_w"};

   int_matrix_vector_transform dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_column_index (req_column_index),
      .req_elem_x       (req_elem_x),
      .req_elem_y       (req_elem_y),
      .req_elem_z       (req_elem_z),
      .req_elem_w       (req_elem_w),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_w        (rsp_out_w)
   );

   always #5 clock = ~clock;

   // Start from the identity matrix
   initial begin
      for (int c = 0; c < LANES; c++) begin
         for (int r = 0; r < LANES; r++) begin
            model_matrix[c][r] = (c == r) ? 32'd1 : 32'd0;
         end
      end
   end

   // Matrix times vector over the leading active rows and columns, wrapping at 32 bits
   function automatic lane_vec_type matrix_times_vector(input lane_vec_type vec);
      lane_vec_type prod;
      logic [31:0]  acc;
      int           size;
      size = int'(model_dimension);
      if (size < 2) begin
         size = 2;
      end
      if (size > imvt_pkg::MAX_DIM) begin
         size = imvt_pkg::MAX_DIM;
      end
      for (int row = 0; row < LANES; row++) begin
         acc = '0;
         if (row < size) begin
            for (int col = 0; col < size; col++) begin
               acc = acc + model_matrix[col][row] * vec[col];
            end
         end
         prod[row] = acc;
      end
      return prod;
   endfunction

   // Apply one accepted transaction to the predictor
   function automatic void track_request(input xform_req_type item);
      if (item.mode == imvt_pkg::MODE_LOAD) begin
         for (int row = 0; row < LANES; row++) begin
            model_matrix[item.column][row] = item.elem[row];
         end
      end else begin
         expected_products.push_back(matrix_times_vector(item.elem));
      end
   endfunction

   // Request driver: predict on acceptance, then present the next pending transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_request('{mode: req_mode, column: req_column_index,
                            elem: {req_elem_w, req_elem_z, req_elem_y, req_elem_x}});
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_mode         <= next_req.mode;
               req_column_index <= next_req.column;
               req_elem_x       <= next_req.elem[0];
               req_elem_y       <= next_req.elem[1];
               req_elem_z       <= next_req.elem[2];
               req_elem_w       <= next_req.elem[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each accepted product, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_product = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, got_product);
               error_count++;
            end else begin
               want_product = expected_products.pop_front();
               for (int i = 0; i < LANES; i++) begin
                  if (got_product[i] !== want_product[i]) begin
                     $display("%0t: %s mismatch, expected %h, actual %h",
                              $time, lane_name[i], want_product[i], got_product[i]);
                     error_count++;
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Queue one transaction for the driver
   task automatic push_item(input logic mode, input logic [1:0] column,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w);
      pending_requests.push_back('{mode: mode, column: column, elem: {w, z, y, x}});
      queued_count++;
   endtask

   // Element value biased toward extremes and small numbers
   function automatic logic [31:0] rand_elem();
      logic [31:0] v;
      case ($urandom_range(9)) inside
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h0000_0000;
         3: v = 32'hFFFF_FFFF;
         4, 5: begin
            v = $urandom_range(31);
            v = v - 32'd16;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Random mix of loads, transforms and full matrix-product sequences
   task automatic push_random(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            for (int c = 0; c < LANES; c++) begin
               push_item(imvt_pkg::MODE_LOAD, 2'(c),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
            end
            for (int c = 0; c < LANES; c++) begin
               push_item(imvt_pkg::MODE_XFORM, 2'($urandom_range(3)),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
            end
            sent += 2 * LANES;
         end else begin
            push_item((pick < 40) ? imvt_pkg::MODE_LOAD : imvt_pkg::MODE_XFORM,
                      2'($urandom_range(3)),
                      rand_elem(), rand_elem(), rand_elem(), rand_elem());
            sent++;
         end
      end
   endtask

   // Hold until every transaction is accepted and every product has come back
   task automatic drain();
      while (accepted_count != queued_count) begin
         @(posedge clock);
      end
      while (expected_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Write the dimension register while the block is idle
   task automatic write_dimension(input logic [imvt_pkg::DIM_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_dimension = value;
   endtask

   // Stimulus sequence
   initial begin
      logic [imvt_pkg::DIM_W-1:0] phase_dims [9];
      phase_dims = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7, 3'd3};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 64;

      // Directed: identity at reset, extreme columns, wrapping sums, load-to-use
      push_item(imvt_pkg::MODE_XFORM, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h0);
      push_item(imvt_pkg::MODE_XFORM, 2'd3, 32'd1, 32'd2, 32'd3, 32'd4);
      push_item(imvt_pkg::MODE_LOAD,  2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
                32'hFFFF_FFFF);
      push_item(imvt_pkg::MODE_LOAD,  2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
      push_item(imvt_pkg::MODE_LOAD,  2'd2, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'd2);
      push_item(imvt_pkg::MODE_LOAD,  2'd3, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
                32'hF0F0_F0F0);
      push_item(imvt_pkg::MODE_XFORM, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      push_item(imvt_pkg::MODE_XFORM, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
      push_item(imvt_pkg::MODE_XFORM, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      push_item(imvt_pkg::MODE_XFORM, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      push_item(imvt_pkg::MODE_XFORM, 2'd3, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                32'hCCCC_CCCC);
      push_item(imvt_pkg::MODE_LOAD,  2'd2, 32'd3, 32'd3, 32'd3, 32'd3);
      push_item(imvt_pkg::MODE_XFORM, 2'd0, 32'd0, 32'd0, 32'd1, 32'd0);
      push_item(imvt_pkg::MODE_LOAD,  2'd0, 32'd1, 32'd0, 32'd0, 32'd0);
      push_item(imvt_pkg::MODE_LOAD,  2'd1, 32'd0, 32'd1, 32'd0, 32'd0);
      push_item(imvt_pkg::MODE_XFORM, 2'd1, 32'd1, 32'd1, 32'd1, 32'd1);
      drain();

      // Random phases across all dimension values and idle patterns
      for (int phase = 0; phase < 9; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_dimension(phase_dims[phase]);
         push_random(56);
         drain();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_products.size() == 0) begin
         $display("int_matrix_vector_transform_tb: PASS");
      end else begin
         $display("int_matrix_vector_transform_tb: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("int_matrix_vector_transform_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/imvt_pkg.sv
hw/rtl/imvt_lane.sv
hw/rtl/imvt_merge.sv
hw/rtl/int_matrix_vector_transform.sv
tb/sv/int_matrix_vector_transform_tb.sv
